### rtl/hclp_pkg.sv
`default_nettype none

package hclp_pkg;

  localparam int unsigned TABLE_ENTRIES = 4096;
  localparam int unsigned PROBE_LIMIT   = 16;

  localparam int unsigned IDX_W   = $clog2(TABLE_ENTRIES);
  localparam int unsigned PCNT_W  = $clog2(PROBE_LIMIT + 1);
  localparam int unsigned CMD_W   = 2;
  localparam int unsigned KEY_W   = 64;
  localparam int unsigned DEPTH_W = 8;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned HALF_W  = KEY_W / 2;

  localparam int unsigned MIX_SHIFT = 33;
  localparam logic [KEY_W-1:0] MIX_C1 = 64'hFF51_AFD7_ED55_8CCD;
  localparam logic [KEY_W-1:0] MIX_C2 = 64'hC4CE_B9FE_1A85_EC53;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_LOOKUP = 2'd1,
    CMD_STORE  = 2'd2
  } cmd_e;

  function automatic logic [KEY_W-1:0] mix_xs(input logic [KEY_W-1:0] x);
    return x ^ (x >> MIX_SHIFT);
  endfunction

endpackage

`default_nettype wire

### rtl/hclp_req_if.sv
`default_nettype none

interface hclp_req_if;
  logic                             valid;
  logic                             ready;
  logic [hclp_pkg::CMD_W-1:0]       command;
  logic [hclp_pkg::KEY_W-1:0]       key;
  logic [hclp_pkg::DEPTH_W-1:0]     search_depth;
  logic [hclp_pkg::VALUE_W-1:0]     value;

  modport source (output valid, command, key, search_depth, value, input ready);
  modport sink   (input valid, command, key, search_depth, value, output ready);
endinterface

`default_nettype wire

### rtl/hclp_rsp_if.sv
`default_nettype none

interface hclp_rsp_if;
  logic                         valid;
  logic                         ready;
  logic                         hit;
  logic [hclp_pkg::VALUE_W-1:0] found_value;

  modport source (output valid, hit, found_value, input ready);
  modport sink   (input valid, hit, found_value, output ready);
endinterface

`default_nettype wire

### rtl/hash_cache_linear_probe_unit.sv
`default_nettype none

// Channel   Dir  Payload                                   Transfer
// req_i     in   command, key, search_depth, value         valid && ready
// rsp_o     out  hit, found_value                          valid && ready
//
// Lookup and store of a nonzero key first hash the key on one shared 32x32 multiplier
// (three partial products per 64-bit multiply), then read one slot per probe,
// pipelined, up to PROBE_LIMIT probes; clear sweeps every entry, and other commands go
// straight to ST_DONE. Reset starts a pass that zeroes every key, and req_i is not
// ready until it ends.
// A result waits in the output register; a stalled rsp_o holds the next one in ST_DONE.

module hash_cache_linear_probe_unit (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  hclp_req_if.sink    req_i,
  hclp_rsp_if.source  rsp_o
);

  localparam int unsigned IDX_W   = hclp_pkg::IDX_W;
  localparam int unsigned PCNT_W  = hclp_pkg::PCNT_W;
  localparam int unsigned KEY_W   = hclp_pkg::KEY_W;
  localparam int unsigned HALF_W  = hclp_pkg::HALF_W;
  localparam int unsigned DEPTH_W = hclp_pkg::DEPTH_W;
  localparam int unsigned VALUE_W = hclp_pkg::VALUE_W;
  localparam int unsigned DV_W    = DEPTH_W + VALUE_W;

  typedef enum logic [2:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_HASH,
    ST_PROBE,
    ST_DONE
  } state_e;

  state_e state_q, state_d;
  logic [IDX_W-1:0]  sweep_cnt_q, sweep_cnt_d;
  logic              pend_clear_q, pend_clear_d;
  logic [1:0]        mstep_q, mstep_d;
  logic              pass_q, pass_d;
  logic [PCNT_W-1:0] issue_cnt_q, issue_cnt_d;
  logic [PCNT_W-1:0] eval_cnt_q, eval_cnt_d;
  logic              rd_vld_q, rd_vld_d;
  logic              out_valid_q, out_valid_d;

  logic [hclp_pkg::CMD_W-1:0] cmd_q, cmd_d;
  logic [KEY_W-1:0]   key_q, key_d;
  logic [DEPTH_W-1:0] depth_q, depth_d;
  logic [VALUE_W-1:0] value_q, value_d;
  logic [KEY_W-1:0]   h_q, h_d;
  logic [KEY_W-1:0]   prod_q, prod_d;
  logic [KEY_W-1:0]   acc_q, acc_d;
  logic [IDX_W-1:0]   probe_addr_q, probe_addr_d;
  logic [IDX_W-1:0]   rd_addr_q, rd_addr_d;
  logic [IDX_W-1:0]   home_q, home_d;
  logic               res_hit_q, res_hit_d;
  logic [VALUE_W-1:0] res_val_q, res_val_d;
  logic               out_hit_q, out_hit_d;
  logic [VALUE_W-1:0] out_val_q, out_val_d;

  logic [KEY_W-1:0] key_mem [hclp_pkg::TABLE_ENTRIES];
  logic [DV_W-1:0]  dv_mem  [hclp_pkg::TABLE_ENTRIES];
  logic [KEY_W-1:0] key_rd_q;
  logic [DV_W-1:0]  dv_rd_q;

  logic             key_we, dv_we, rd_en;
  logic [IDX_W-1:0] wr_addr;
  logic [KEY_W-1:0] wr_key;

  logic              req_fire, out_free;
  logic [KEY_W-1:0]  mix_c;
  logic [HALF_W-1:0] mul_a, mul_b;
  logic [KEY_W-1:0]  mul_p, acc_sum, hash_fin;
  logic              slot_empty, slot_match, probe_last, probe_issue, depth_ok;

  assign req_i.ready       = (state_q == ST_IDLE);
  assign req_fire          = req_i.valid && req_i.ready;
  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.hit         = out_hit_q;
  assign rsp_o.found_value = out_val_q;
  assign out_free          = !out_valid_q || rsp_o.ready;

  assign mix_c    = pass_q ? hclp_pkg::MIX_C2 : hclp_pkg::MIX_C1;
  assign mul_a    = (mstep_q == 2'd1) ? h_q[KEY_W-1:HALF_W] : h_q[HALF_W-1:0];
  assign mul_b    = (mstep_q == 2'd2) ? mix_c[KEY_W-1:HALF_W] : mix_c[HALF_W-1:0];
  assign mul_p    = KEY_W'(mul_a) * KEY_W'(mul_b);
  assign acc_sum  = acc_q + {prod_q[HALF_W-1:0], {HALF_W{1'b0}}};
  assign hash_fin = hclp_pkg::mix_xs(acc_sum);

  assign slot_empty  = (key_rd_q == '0);
  assign slot_match  = (key_rd_q == key_q);
  assign probe_last  = (eval_cnt_q == PCNT_W'(hclp_pkg::PROBE_LIMIT - 1));
  assign probe_issue = (issue_cnt_q != PCNT_W'(hclp_pkg::PROBE_LIMIT));
  assign depth_ok    = (dv_rd_q[DV_W-1:VALUE_W] <= depth_q);

  always_comb begin
    state_d      = state_q;
    sweep_cnt_d  = sweep_cnt_q;
    pend_clear_d = pend_clear_q;
    mstep_d      = mstep_q;
    pass_d       = pass_q;
    issue_cnt_d  = issue_cnt_q;
    eval_cnt_d   = eval_cnt_q;
    rd_vld_d     = rd_vld_q;
    out_valid_d  = out_valid_q;
    cmd_d        = cmd_q;
    key_d        = key_q;
    depth_d      = depth_q;
    value_d      = value_q;
    h_d          = h_q;
    prod_d       = prod_q;
    acc_d        = acc_q;
    probe_addr_d = probe_addr_q;
    rd_addr_d    = rd_addr_q;
    home_d       = home_q;
    res_hit_d    = res_hit_q;
    res_val_d    = res_val_q;
    out_hit_d    = out_hit_q;
    out_val_d    = out_val_q;
    key_we       = 1'b0;
    dv_we        = 1'b0;
    rd_en        = 1'b0;
    wr_addr      = rd_addr_q;
    wr_key       = key_q;

    if (out_valid_q && rsp_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_SWEEP: begin
        key_we      = 1'b1;
        wr_addr     = sweep_cnt_q;
        wr_key      = '0;
        sweep_cnt_d = sweep_cnt_q + IDX_W'(1);
        if (sweep_cnt_q == '1) begin
          if (pend_clear_q) begin
            pend_clear_d = 1'b0;
            state_d      = ST_DONE;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_IDLE: begin
        if (req_fire) begin
          cmd_d     = req_i.command;
          key_d     = req_i.key;
          depth_d   = req_i.search_depth;
          value_d   = req_i.value;
          h_d       = hclp_pkg::mix_xs(req_i.key);
          mstep_d   = 2'd0;
          pass_d    = 1'b0;
          res_hit_d = 1'b0;
          res_val_d = '0;
          case (req_i.command)
            hclp_pkg::CMD_CLEAR: begin
              pend_clear_d = 1'b1;
              sweep_cnt_d  = '0;
              state_d      = ST_SWEEP;
            end
            hclp_pkg::CMD_LOOKUP, hclp_pkg::CMD_STORE: begin
              state_d = (req_i.key == '0) ? ST_DONE : ST_HASH;
            end
            default: begin
              state_d = ST_DONE;
            end
          endcase
        end
      end
      ST_HASH: begin
        prod_d  = mul_p;
        mstep_d = mstep_q + 2'd1;
        case (mstep_q)
          2'd0: begin
          end
          2'd1: begin
            acc_d = prod_q;
          end
          2'd2: begin
            acc_d = acc_sum;
          end
          default: begin
            h_d = hash_fin;
            if (pass_q) begin
              probe_addr_d = hash_fin[IDX_W-1:0];
              home_d       = hash_fin[IDX_W-1:0];
              issue_cnt_d  = '0;
              eval_cnt_d   = '0;
              rd_vld_d     = 1'b0;
              state_d      = ST_PROBE;
            end else begin
              pass_d = 1'b1;
            end
          end
        endcase
      end
      ST_PROBE: begin
        rd_en    = probe_issue;
        rd_vld_d = probe_issue;
        if (probe_issue) begin
          probe_addr_d = probe_addr_q + IDX_W'(1);
          issue_cnt_d  = issue_cnt_q + PCNT_W'(1);
          rd_addr_d    = probe_addr_q;
        end
        if (rd_vld_q) begin
          eval_cnt_d = eval_cnt_q + PCNT_W'(1);
          if (slot_empty || slot_match || probe_last) begin
            state_d = ST_DONE;
          end
          if (cmd_q == hclp_pkg::CMD_LOOKUP) begin
            if (slot_match && depth_ok) begin
              res_hit_d = 1'b1;
              res_val_d = dv_rd_q[VALUE_W-1:0];
            end
          end else if (slot_empty || slot_match || probe_last) begin
            key_we  = 1'b1;
            dv_we   = 1'b1;
            wr_addr = (slot_empty || slot_match) ? rd_addr_q : home_q;
          end
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_hit_d   = res_hit_q;
          out_val_d   = res_val_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_SWEEP;
      sweep_cnt_q  <= '0;
      pend_clear_q <= 1'b0;
      mstep_q      <= 2'd0;
      pass_q       <= 1'b0;
      issue_cnt_q  <= '0;
      eval_cnt_q   <= '0;
      rd_vld_q     <= 1'b0;
      out_valid_q  <= 1'b0;
      out_hit_q    <= 1'b0;
      out_val_q    <= '0;
    end else begin
      state_q      <= state_d;
      sweep_cnt_q  <= sweep_cnt_d;
      pend_clear_q <= pend_clear_d;
      mstep_q      <= mstep_d;
      pass_q       <= pass_d;
      issue_cnt_q  <= issue_cnt_d;
      eval_cnt_q   <= eval_cnt_d;
      rd_vld_q     <= rd_vld_d;
      out_valid_q  <= out_valid_d;
      out_hit_q    <= out_hit_d;
      out_val_q    <= out_val_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q        <= cmd_d;
    key_q        <= key_d;
    depth_q      <= depth_d;
    value_q      <= value_d;
    h_q          <= h_d;
    prod_q       <= prod_d;
    acc_q        <= acc_d;
    probe_addr_q <= probe_addr_d;
    rd_addr_q    <= rd_addr_d;
    home_q       <= home_d;
    res_hit_q    <= res_hit_d;
    res_val_q    <= res_val_d;
  end

  always_ff @(posedge clk_i) begin
    if (key_we) begin
      key_mem[wr_addr] <= wr_key;
    end
    if (rd_en) begin
      key_rd_q <= key_mem[probe_addr_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (dv_we) begin
      dv_mem[wr_addr] <= {depth_q, value_q};
    end
    if (rd_en) begin
      dv_rd_q <= dv_mem[probe_addr_q];
    end
  end

endmodule

`default_nettype wire

### verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import hclp_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int unsigned RANDOM_ITEMS = 2000;
  localparam int unsigned CLUSTER_KEYS = 32;
  localparam int unsigned SPREAD_KEYS  = 48;
  localparam int unsigned DRAIN_CYCLES = 32;
  localparam int unsigned CYCLE_LIMIT  = 2_000_000;

  typedef struct packed {
    logic               hit;
    logic [VALUE_W-1:0] found_value;
  } outcome_t;

  class probe_table;
    logic [KEY_W-1:0]   slot_key   [TABLE_ENTRIES];
    logic [DEPTH_W-1:0] slot_depth [TABLE_ENTRIES];
    logic [VALUE_W-1:0] slot_value [TABLE_ENTRIES];
    outcome_t           awaited_outcomes[$];
    int unsigned        errors;

    function new();
      foreach (slot_key[i]) begin
        slot_key[i]   = '0;
        slot_depth[i] = '0;
        slot_value[i] = '0;
      end
      errors = 0;
    endfunction

    function int unsigned home_of(logic [KEY_W-1:0] key);
      logic [KEY_W-1:0] h;
      h = key;
      h = h ^ (h >> 33);
      h = h * 64'hFF51_AFD7_ED55_8CCD;
      h = h ^ (h >> 33);
      h = h * 64'hC4CE_B9FE_1A85_EC53;
      h = h ^ (h >> 33);
      return int'(h % TABLE_ENTRIES);
    endfunction

    function int outstanding();
      return awaited_outcomes.size();
    endfunction

    function void note_request(logic [CMD_W-1:0] cmd, logic [KEY_W-1:0] key,
                               logic [DEPTH_W-1:0] depth, logic [VALUE_W-1:0] val);
      outcome_t    res;
      int unsigned home;
      int unsigned slot;
      int unsigned target;
      bit          done;
      res  = '0;
      home = home_of(key);
      done = 1'b0;
      case (cmd)
        CMD_CLEAR: begin
          foreach (slot_key[i]) slot_key[i] = '0;
        end
        CMD_LOOKUP: begin
          for (int i = 0; i < PROBE_LIMIT && !done; i++) begin
            slot = (home + i) % TABLE_ENTRIES;
            if (slot_key[slot] == '0) begin
              done = 1'b1;
            end else if (slot_key[slot] == key) begin
              done = 1'b1;
              if (slot_depth[slot] <= depth) begin
                res.hit         = 1'b1;
                res.found_value = slot_value[slot];
              end
            end
          end
        end
        CMD_STORE: begin
          if (key != '0) begin
            target = home;
            for (int i = 0; i < PROBE_LIMIT && !done; i++) begin
              slot = (home + i) % TABLE_ENTRIES;
              if (slot_key[slot] == '0 || slot_key[slot] == key) begin
                target = slot;
                done   = 1'b1;
              end
            end
            slot_key[target]   = key;
            slot_depth[target] = depth;
            slot_value[target] = val;
          end
        end
        default: ;
      endcase
      awaited_outcomes.push_back(res);
    endfunction

    function void check_response(logic hit, logic [VALUE_W-1:0] found_value);
      outcome_t want;
      if (awaited_outcomes.size() == 0) begin
        $display("%0t: unexpected transfer, expected none, actual hit %0b found_value %h",
                 $time, hit, found_value);
        errors++;
        return;
      end
      want = awaited_outcomes.pop_front();
      if (hit !== want.hit) begin
        $display("%0t: hit expected %0b actual %0b", $time, want.hit, hit);
        errors++;
      end
      if (found_value !== want.found_value) begin
        $display("%0t: found_value expected %h actual %h", $time, want.found_value,
                 found_value);
        errors++;
      end
    endfunction
  endclass

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  hclp_req_if req_if();
  hclp_rsp_if rsp_if();

  hash_cache_linear_probe_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  probe_table       tracker = new();
  logic [KEY_W-1:0] cluster_keys [CLUSTER_KEYS];
  logic [KEY_W-1:0] spread_keys  [SPREAD_KEYS];
  int unsigned      burst_left;
  int unsigned      cycle_count = 0;

  logic        take_q = 1'b0;
  logic [15:0] stall_pat;
  logic [5:0]  pat_age;

  assign rsp_if.ready = take_q;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      take_q    <= 1'b0;
      stall_pat <= '1;
      pat_age   <= '0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        tracker.check_response(rsp_if.hit, rsp_if.found_value);
      end
      if (pat_age == '1) begin
        stall_pat <= ($urandom_range(0, 3) == 0) ? 16'hFFFF : (16'($urandom) | 16'h1);
      end else begin
        stall_pat <= {stall_pat[0], stall_pat[15:1]};
      end
      pat_age <= pat_age + 1'b1;
      take_q  <= stall_pat[0];
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic int unsigned next_burst();
    return ($urandom_range(0, 4) == 0) ? 40 : $urandom_range(1, 10);
  endfunction

  function automatic logic [KEY_W-1:0] pick_key();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return cluster_keys[$urandom_range(0, CLUSTER_KEYS - 1)];
    if (r < 82) return spread_keys[$urandom_range(0, SPREAD_KEYS - 1)];
    if (r < 84) return '0;
    return {$urandom, $urandom};
  endfunction

  function automatic logic [DEPTH_W-1:0] pick_depth();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return DEPTH_W'($urandom_range(0, 255));
  endfunction

  // hold the transfer until accepted, then idle between bursts
  task automatic issue(input logic [CMD_W-1:0] cmd, input logic [KEY_W-1:0] key,
                       input logic [DEPTH_W-1:0] depth, input logic [VALUE_W-1:0] val);
    req_if.valid        <= 1'b1;
    req_if.command      <= cmd;
    req_if.key          <= key;
    req_if.search_depth <= depth;
    req_if.value        <= val;
    do @(posedge clk_i); while (!req_if.ready);
    tracker.note_request(cmd, key, depth, val);
    burst_left--;
    if (burst_left == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
      burst_left = next_burst();
    end
  endtask

  initial begin
    logic [KEY_W-1:0]   key;
    logic [KEY_W-1:0]   c0;
    logic [KEY_W-1:0]   c1;
    logic [CMD_W-1:0]   cmd;
    int unsigned        n;
    int unsigned        h;
    int unsigned        r;
    int unsigned        counted;

    req_if.valid        <= 1'b0;
    req_if.command      <= CMD_CLEAR;
    req_if.key          <= '0;
    req_if.search_depth <= '0;
    req_if.value        <= '0;

    // gather keys whose home slots crowd the wrap point of the table
    n = 0;
    while (n < CLUSTER_KEYS) begin
      key = {$urandom, $urandom};
      h   = tracker.home_of(key);
      if (key != '0 && (h >= TABLE_ENTRIES - 4 || h < 4)) begin
        cluster_keys[n] = key;
        n++;
      end
    end
    foreach (spread_keys[i]) spread_keys[i] = {$urandom, $urandom} | 64'h1;
    c0 = cluster_keys[0];
    c1 = cluster_keys[1];

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    burst_left = next_burst();

    issue(CMD_LOOKUP, '0, '1, '0);
    issue(CMD_STORE, '0, '0, '1);
    issue(CMD_LOOKUP, '0, '1, '0);
    issue(CMD_STORE, '1, '0, '1);
    issue(CMD_LOOKUP, '1, '0, '0);
    issue(CMD_LOOKUP, '1, '1, '0);
    issue(CMD_STORE, c0, '1, '0);
    issue(CMD_LOOKUP, c0, 8'd254, '0);
    issue(CMD_LOOKUP, c0, '1, '0);
    issue(CMD_STORE, c0, 8'd10, 32'hA5A5_A5A5);
    issue(CMD_LOOKUP, c0, 8'd10, '0);
    issue(CMD_UNUSED, '1, '1, '1);
    issue(CMD_LOOKUP, c1, '1, '0);
    issue(CMD_CLEAR, '0, '0, '0);
    issue(CMD_LOOKUP, '1, '1, '0);
    issue(CMD_LOOKUP, c0, '1, '0);

    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 2)       cmd = CMD_CLEAR;
      else if (r < 5)  cmd = CMD_UNUSED;
      else if (r < 52) cmd = CMD_LOOKUP;
      else             cmd = CMD_STORE;
      key = pick_key();
      issue(cmd, key, pick_depth(), $urandom);
      if (!(cmd == CMD_UNUSED || (cmd == CMD_STORE && key == '0))) counted++;
    end
    req_if.valid <= 1'b0;

    while (tracker.outstanding() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (tracker.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
